[src/axdr_element_value_extractor_top_macros.svh]
// Assertion macros used by the checker file of the element value extractor.
`ifndef AXDR_ELEMENT_VALUE_EXTRACTOR_TOP_MACROS_SVH
`define AXDR_ELEMENT_VALUE_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AXDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("axdr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AXDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("axdr assertion failed");

`endif

[src/axdr_pkg.sv]
// Shared types, constants and helper functions of the element value extractor.
`default_nettype none
package axdr_pkg;

	localparam int FRAME_DEPTH_DEF = 512;

	// Commands carried by an input transaction.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_INT   = 2'd1;
	localparam logic [1:0] CMD_ETIME = 2'd2;
	localparam logic [1:0] CMD_PTIME = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_HEADER_OFFSET = 2'd0;
	localparam logic [1:0] REG_HEADER_FIX    = 2'd1;

	// A-XDR type tags.
	localparam logic [7:0] TAG_NULL      = 8'h00;
	localparam logic [7:0] TAG_ARRAY     = 8'h01;
	localparam logic [7:0] TAG_STRUCT    = 8'h02;
	localparam logic [7:0] TAG_OCTETS    = 8'h09;
	localparam logic [7:0] TAG_VISIBLE   = 8'h0A;
	localparam logic [7:0] TAG_INT8      = 8'h0F;
	localparam logic [7:0] TAG_INT16     = 8'h10;
	localparam logic [7:0] TAG_UINT16    = 8'h12;
	localparam logic [7:0] TAG_UINT32    = 8'h06;
	localparam logic [7:0] TAG_ENUM      = 8'h16;
	localparam logic [7:0] TIME_LEN      = 8'h0C;

	// Payload header signature.
	localparam logic [7:0] HDR_B0 = 8'hE6;
	localparam logic [7:0] HDR_B1 = 8'hE7;
	localparam logic [7:0] HDR_B2 = 8'h00;
	localparam logic [7:0] HDR_B3 = 8'h0F;
	localparam int HDR_MIN_BYTES  = 9;

	// Date arithmetic constants.
	localparam logic [15:0] YEAR_EPOCH         = 16'd1970;
	localparam logic [31:0] DAYS_PER_YEAR      = 32'd365;
	localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
	localparam logic [31:0] SECS_PER_HOUR      = 32'd3600;
	localparam logic [31:0] SECS_PER_MIN       = 32'd60;
	localparam logic [31:0] LEAPS_BEFORE_EPOCH = 32'd477;
	// ceil(2^23 / 100) == ceil(2^25 / 400): exact quotients for 16-bit values.
	localparam logic [32:0] RECIP_DIV          = 33'd83887;
	localparam int TIME_BYTES = 9;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic       first;
		logic [7:0] element_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic        found;
		logic        header_ok;
	} out_item_t;

	typedef struct packed {
		logic       known;
		logic       is_len;
		logic [2:0] skip;
		logic [2:0] int_len;
	} tag_info_t;

	typedef enum logic [2:0] {
		ADDR_LOAD,
		ADDR_H,
		ADDR_POS,
		ADDR_POS1,
		ADDR_FETCH
	} addr_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_INT,
		RES_TIME
	} res_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      accept;
		addr_sel_t addr_sel;
		logic      pos_from_h;
		logic      step_pos;
		logic      dec_left;
		logic      len_pos;
		logic      fetch_init;
		logic      fetch_cap;
		logic      time1;
		logic      time2;
		logic      time3;
		logic      res_load;
		res_kind_t res_kind;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] in_cmd;
		logic [1:0] cmd;
		logic       past_end;
		logic       left_zero;
		tag_info_t  tag;
		logic       fetch_last;
		logic       time_ok;
		logic       out_free;
	} sts_t;

	// Classify a type tag: bytes skipped after it and integer length.
	function automatic tag_info_t tag_decode(input logic [7:0] tag);
		tag_info_t t;
		t = '{known: 1'b1, is_len: 1'b0, skip: 3'd0, int_len: 3'd0};
		unique case (tag)
			TAG_NULL: begin
			end
			TAG_VISIBLE, TAG_OCTETS: begin
				t.is_len = 1'b1;
			end
			TAG_ARRAY, TAG_STRUCT, TAG_INT8, TAG_ENUM: begin
				t.skip = 3'd1;
				t.int_len = 3'd1;
			end
			TAG_INT16, TAG_UINT16: begin
				t.skip = 3'd2;
				t.int_len = 3'd2;
			end
			TAG_UINT32: begin
				t.skip = 3'd4;
				t.int_len = 3'd4;
			end
			default: begin
				t.known = 1'b0;
			end
		endcase
		return t;
	endfunction

	// Days before the given month; month zero adds none, large months clamp.
	function automatic logic [8:0] days_before_month(input logic [7:0] month);
		logic [8:0] d;
		priority if (month == 8'd0)  d = 9'd0;
		else if (month == 8'd1)  d = 9'd0;
		else if (month == 8'd2)  d = 9'd31;
		else if (month == 8'd3)  d = 9'd59;
		else if (month == 8'd4)  d = 9'd90;
		else if (month == 8'd5)  d = 9'd120;
		else if (month == 8'd6)  d = 9'd151;
		else if (month == 8'd7)  d = 9'd181;
		else if (month == 8'd8)  d = 9'd212;
		else if (month == 8'd9)  d = 9'd243;
		else if (month == 8'd10) d = 9'd273;
		else if (month == 8'd11) d = 9'd304;
		else if (month == 8'd12) d = 9'd334;
		else d = 9'd365;
		return d;
	endfunction

endpackage
`default_nettype wire

[src/axdr_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module axdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[src/axdr_ctrl.sv]
// Controller state machine that sequences loads, the element walk and time conversion.
`default_nettype none
module axdr_ctrl
	import axdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b000000000001,
		ST_H_RD      = 12'b000000000010,
		ST_H_USE     = 12'b000000000100,
		ST_TAG_CHK   = 12'b000000001000,
		ST_TAG_USE   = 12'b000000010000,
		ST_LEN_USE   = 12'b000000100000,
		ST_FETCH_RD  = 12'b000001000000,
		ST_FETCH_USE = 12'b000010000000,
		ST_TIME1     = 12'b000100000000,
		ST_TIME2     = 12'b001000000000,
		ST_TIME3     = 12'b010000000000,
		ST_RESULT    = 12'b100000000000
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		ctl = '{accept: 1'b0, addr_sel: ADDR_LOAD, pos_from_h: 1'b0, step_pos: 1'b0,
			dec_left: 1'b0, len_pos: 1'b0, fetch_init: 1'b0, fetch_cap: 1'b0,
			time1: 1'b0, time2: 1'b0, time3: 1'b0, res_load: 1'b0, res_kind: kind_q};
		unique case (state_q)
			ST_IDLE: begin
				ctl.accept = in_valid;
				if (in_valid && sts.in_cmd != CMD_LOAD) begin
					state_d = ST_H_RD;
				end
			end
			ST_H_RD: begin
				ctl.addr_sel = ADDR_H;
				state_d = ST_H_USE;
			end
			ST_H_USE: begin
				if (sts.cmd == CMD_PTIME) begin
					ctl.fetch_init = 1'b1;
					state_d = ST_FETCH_RD;
				end else begin
					ctl.pos_from_h = 1'b1;
					state_d = ST_TAG_CHK;
				end
			end
			ST_TAG_CHK: begin
				ctl.addr_sel = ADDR_POS;
				if (sts.past_end) begin
					kind_d  = RES_NONE;
					state_d = ST_RESULT;
				end else begin
					state_d = ST_TAG_USE;
				end
			end
			ST_TAG_USE: begin
				ctl.addr_sel = ADDR_POS1;
				if (sts.left_zero) begin
					// Element reached: gather its data bytes.
					ctl.fetch_init = 1'b1;
					if (sts.cmd == CMD_INT && sts.tag.int_len == 3'd0) begin
						kind_d  = RES_INT;
						state_d = ST_RESULT;
					end else begin
						state_d = ST_FETCH_RD;
					end
				end else if (!sts.tag.known) begin
					kind_d  = RES_NONE;
					state_d = ST_RESULT;
				end else begin
					ctl.dec_left = 1'b1;
					if (sts.tag.is_len) begin
						state_d = ST_LEN_USE;
					end else begin
						ctl.step_pos = 1'b1;
						state_d = ST_TAG_CHK;
					end
				end
			end
			ST_LEN_USE: begin
				ctl.len_pos = 1'b1;
				state_d = ST_TAG_CHK;
			end
			ST_FETCH_RD: begin
				ctl.addr_sel = ADDR_FETCH;
				state_d = ST_FETCH_USE;
			end
			ST_FETCH_USE: begin
				ctl.fetch_cap = 1'b1;
				if (sts.fetch_last) begin
					if (sts.cmd == CMD_INT) begin
						kind_d  = RES_INT;
						state_d = ST_RESULT;
					end else begin
						state_d = ST_TIME1;
					end
				end else begin
					state_d = ST_FETCH_RD;
				end
			end
			ST_TIME1: begin
				if (!sts.time_ok) begin
					kind_d  = RES_NONE;
					state_d = ST_RESULT;
				end else begin
					ctl.time1 = 1'b1;
					state_d = ST_TIME2;
				end
			end
			ST_TIME2: begin
				ctl.time2 = 1'b1;
				state_d = ST_TIME3;
			end
			ST_TIME3: begin
				ctl.time3 = 1'b1;
				kind_d  = RES_TIME;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RES_NONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule
`default_nettype wire

[src/axdr_dpath.sv]
// Datapath: payload store, walk position, byte fetch, date arithmetic and result register.
`default_nettype none
module axdr_dpath
	import axdr_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire ctl_t      ctl,
	output sts_t           sts,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int PW = ((AW > 10) ? AW : 10) + 2;
	localparam int CW = $clog2(FRAME_DEPTH + 1);

	// Control registers.
	logic [CW-1:0] byte_count_q;
	logic [8:0]    header_offset_q;
	logic          header_fix_q;
	logic          out_valid_q;

	// Payload registers.
	logic [1:0]    cmd_q;
	logic [7:0]    idx_q;
	logic [7:0]    left_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] base_q;
	logic [3:0]    cnt_q;
	logic [3:0]    fk_q;
	logic [7:0]    tb_q [TIME_BYTES];
	logic          oor_q;
	logic [7:0]    hdr_q [4];
	logic [32:0]   pn_s1, py_s1;
	logic [31:0]   ydays_s1;
	logic [31:0]   days_s2, hms_s2;
	logic [31:0]   time_s3;
	out_item_t     out_q;

	logic [CW-1:0] ld_addr;
	logic          ld_in;
	logic          is_load;
	logic [PW-1:0] h_pos;
	logic [PW-1:0] addr_p;
	logic          ram_we;
	logic [7:0]    ram_q;
	logic [7:0]    rbyte;
	tag_info_t     tag;
	logic [15:0]   year, year_m1;
	logic [7:0]    month, day, hour, minute, second;
	logic [31:0]   leaps;
	logic          leap;
	logic [9:0]    yq100;
	logic [7:0]    yq400;
	logic [31:0]   value_d;
	logic          hok;

	// Load address and header base.
	assign is_load = ctl.accept && (in_data.cmd == CMD_LOAD);
	assign ld_addr = in_data.first ? '0 : byte_count_q;
	assign ld_in   = (32'(ld_addr) < FRAME_DEPTH);
	assign h_pos   = PW'(header_offset_q) + PW'(header_fix_q);
	assign ram_we  = is_load && ld_in;

	// Read address selection.
	always_comb begin
		unique case (ctl.addr_sel)
			ADDR_LOAD:  addr_p = PW'(ld_addr);
			ADDR_H:     addr_p = h_pos;
			ADDR_POS:   addr_p = pos_q;
			ADDR_POS1:  addr_p = pos_q + PW'(1);
			ADDR_FETCH: addr_p = base_q + PW'(fk_q);
			default:    addr_p = '0;
		endcase
	end

	axdr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (addr_p[AW-1:0]),
		.wdata(in_data.data_byte),
		.rdata(ram_q)
	);

	// Addresses beyond the store read as zero.
	assign rbyte = oor_q ? 8'd0 : ram_q;
	assign tag   = tag_decode(rbyte);

	// Date fields of a fetched date-time.
	assign year    = {tb_q[1], tb_q[2]};
	assign year_m1 = year - 16'd1;
	assign month   = tb_q[3];
	assign day     = tb_q[4];
	assign hour    = tb_q[6];
	assign minute  = tb_q[7];
	assign second  = tb_q[8];

	// Leap day counts from the registered reciprocal products.
	assign leaps = 32'(year_m1[15:2]) - 32'(pn_s1[32:23]) + 32'(pn_s1[32:25])
		- LEAPS_BEFORE_EPOCH;
	assign yq100 = py_s1[32:23];
	assign yq400 = py_s1[32:25];
	assign leap  = (year[1:0] == 2'b00) &&
		((16'(yq100) * 16'd100 != year) || (16'(yq400) * 16'd400 == year));

	// Status to the controller.
	assign sts.in_cmd     = in_data.cmd;
	assign sts.cmd        = cmd_q;
	assign sts.past_end   = (pos_q >= PW'(byte_count_q));
	assign sts.left_zero  = (left_q == 8'd0);
	assign sts.tag        = tag;
	assign sts.fetch_last = (fk_q + 4'd1 == cnt_q);
	assign sts.time_ok    = (tb_q[0] == TIME_LEN);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// Result value and header check.
	always_comb begin
		unique case (ctl.res_kind)
			RES_INT:  value_d = {tb_q[5], tb_q[6], tb_q[7], tb_q[8]};
			RES_TIME: value_d = time_s3;
			default:  value_d = 32'd0;
		endcase
	end
	assign hok = (32'(byte_count_q) >= HDR_MIN_BYTES) && (hdr_q[0] == HDR_B0) &&
		(hdr_q[1] == HDR_B1) && (hdr_q[2] == HDR_B2) && (hdr_q[3] == HDR_B3);

	// Control registers: fill count, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_offset_q <= 9'd8;
			header_fix_q    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (ram_we) begin
				byte_count_q <= ld_addr + CW'(1);
			end
			if (cfg_we && cfg_index == REG_HEADER_OFFSET) begin
				header_offset_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_HEADER_FIX) begin
				header_fix_q <= cfg_data[0];
			end
			if (ctl.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk, fetch and arithmetic registers.
	always_ff @(posedge clk) begin
		oor_q <= (addr_p >= PW'(FRAME_DEPTH));
		if (ram_we && ld_addr < CW'(4)) begin
			hdr_q[ld_addr[1:0]] <= in_data.data_byte;
		end
		if (ctl.accept) begin
			cmd_q <= in_data.cmd;
			idx_q <= in_data.element_index;
		end
		if (ctl.pos_from_h) begin
			pos_q  <= h_pos + PW'(rbyte) + PW'(1);
			left_q <= idx_q;
		end else begin
			if (ctl.dec_left) begin
				left_q <= left_q - 8'd1;
			end
			if (ctl.step_pos) begin
				pos_q <= pos_q + PW'(tag.skip) + PW'(1);
			end else if (ctl.len_pos) begin
				pos_q <= pos_q + PW'(rbyte) + PW'(2);
			end
		end
		if (ctl.fetch_init) begin
			base_q <= (cmd_q == CMD_PTIME) ? h_pos : pos_q + PW'(1);
			cnt_q  <= (cmd_q == CMD_INT) ? 4'(tag.int_len) : 4'(TIME_BYTES);
			fk_q   <= 4'd0;
			for (int k = 0; k < TIME_BYTES; k++) begin
				tb_q[k] <= 8'd0;
			end
		end else if (ctl.fetch_cap) begin
			fk_q <= fk_q + 4'd1;
			for (int k = 0; k < TIME_BYTES - 1; k++) begin
				tb_q[k] <= tb_q[k+1];
			end
			tb_q[TIME_BYTES-1] <= rbyte;
		end
		if (ctl.time1) begin
			pn_s1    <= {17'd0, year_m1} * RECIP_DIV;
			py_s1    <= {17'd0, year} * RECIP_DIV;
			ydays_s1 <= (32'(year) - 32'(YEAR_EPOCH)) * DAYS_PER_YEAR;
		end
		if (ctl.time2) begin
			days_s2 <= ydays_s1 + ((year > YEAR_EPOCH) ? leaps : 32'd0)
				+ ((month > 8'd2 && leap) ? 32'd1 : 32'd0)
				+ 32'(days_before_month(month)) + 32'(day) - 32'd1;
			hms_s2  <= 32'(hour) * SECS_PER_HOUR + 32'(minute) * SECS_PER_MIN
				+ 32'(second);
		end
		if (ctl.time3) begin
			time_s3 <= days_s2 * SECS_PER_DAY + hms_s2;
		end
		if (ctl.res_load) begin
			out_q.value     <= value_d;
			out_q.found     <= (ctl.res_kind != RES_NONE);
			out_q.header_ok <= hok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

[src/axdr_element_value_extractor_top.sv]
// Load: bytes are taken back to back; no result transaction.
// Query: the header read, then the walk over skipped elements (string tags take an extra step),
// then the byte fetch (up to 4 integer bytes or 9 date-time bytes), the date math and the result out.
// The single RAM read port and the sequential element walk set the pace of a query.
// One query is worked at a time; the next transaction is taken while a result waits.
// Reset clears the byte count, configuration and control state; the store is not cleared.
`default_nettype none
module axdr_element_value_extractor_top
	import axdr_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data
);

	ctl_t ctl;
	sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	axdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.ctl     (ctl)
	);

	axdr_dpath #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

[src/axdr_checker.sv]
// Port-level checker of the element value extractor and its bind.
`default_nettype none
`include "axdr_element_value_extractor_top_macros.svh"
module axdr_checker
	import axdr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire in_item_t   in_data,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire out_item_t  out_data,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [8:0] cfg_data
);

	// A stalled result transaction stays and holds its payload.
	`AXDR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// A result that was not found carries a zero value.
	`AXDR_ASSERT_SAME(a_zero_missing, clk, arst_n, out_valid && !out_data.found, out_data.value == 32'd0)

	// A query keeps the input side busy in the following cycle.
	`AXDR_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && in_data.cmd != CMD_LOAD, in_stall)

	// A load leaves the input side free for the next byte.
	`AXDR_ASSERT_NEXT(a_load_free, clk, arst_n, in_valid && !in_stall && in_data.cmd == CMD_LOAD, !in_stall)

endmodule

bind axdr_element_value_extractor_top axdr_checker u_chk (.*);
`default_nettype wire
